FILE: hw/rtl/gjr_pkg.sv
`default_nettype none
package gjr_pkg;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [3:0] REG_ROWS = 4'd0;
  localparam logic [3:0] REG_COLS = 4'd1;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_READ,
    CMD_WRITE,
    CMD_DIV,
    CMD_MSUB
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [3:0] rd_row;
    logic [3:0] rd_col;
    logic [3:0] wr_row;
    logic [3:0] wr_col;
    logic [1:0] sel;     // which holding register a read lands in / write sources
  } dp_cmd_t;

  typedef struct packed {
    logic        div_busy;
    logic        rd_zero;
  } dp_stat_t;

  // read destinations
  localparam logic [1:0] SEL_A   = 2'd0;  // element
  localparam logic [1:0] SEL_P   = 2'd1;  // pivot / factor
  localparam logic [1:0] SEL_B   = 2'd2;  // second element
  localparam logic [1:0] SEL_RES = 2'd3;  // write source: result register
endpackage
`default_nettype wire

FILE: hw/rtl/gjr_if.sv
`default_nettype none
interface gjr_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface gjr_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic        last;
  modport source (output valid, output value, output row_index, output col_index,
                  output last, input ready);
  modport sink (input valid, input value, input row_index, input col_index,
                input last, output ready);
endinterface

interface gjr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gjr_datapath.sv
`default_nettype none
module gjr_datapath #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_COLS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  gjr_pkg::dp_cmd_t  cmd,
  input  wire [31:0]        load_data,
  output gjr_pkg::dp_stat_t stat,
  output logic [31:0]       rd_data
);
  import gjr_pkg::*;

  localparam int RB    = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
  localparam int CB    = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AB    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int QW    = 32 + FRAC_BITS;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q_r;
  logic [1:0]  rd_sel_r;
  logic        rd_vld_r;
  logic [31:0] a_r, p_r, b_r, res_r;
  logic signed [63:0] prod_r;
  logic        msub_r;

  logic [AB-1:0] rd_addr, wr_addr;
  assign rd_addr = AB'(32'(cmd.rd_row[RB-1:0]) * MAX_COLS + 32'(cmd.rd_col[CB-1:0]));
  assign wr_addr = AB'(32'(cmd.wr_row[RB-1:0]) * MAX_COLS + 32'(cmd.wr_col[CB-1:0]));

  // memory: one write, one registered read held until the next read
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      mem[wr_addr] <= load_data;
    end else if (cmd.op == CMD_WRITE) begin
      mem[wr_addr] <= (cmd.sel == SEL_A) ? a_r : (cmd.sel == SEL_B) ? b_r : res_r;
    end
    if (cmd.op == CMD_READ) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_sel_r <= SEL_A;
    end else begin
      rd_vld_r <= (cmd.op == CMD_READ);
      rd_sel_r <= cmd.sel;
    end
  end

  // land read data in holding registers; a pivot read also lands as the dividend
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_sel_r)
        SEL_A:   a_r <= rd_q_r;
        SEL_P: begin
          p_r <= rd_q_r;
          a_r <= rd_q_r;
        end
        default: b_r <= rd_q_r;
      endcase
    end
  end
  assign rd_data = rd_q_r;

  // divider: restoring, one quotient bit a cycle on magnitudes
  logic [QW-1:0] num_r, quo_r;
  logic [32:0]   rem_r, den_r;
  logic [6:0]    cnt_r;
  logic          busy_r, neg_r, fin_r;
  logic [33:0]   trial;
  assign trial = {rem_r, num_r[QW-1]} - {1'b0, den_r};

  // multiply-subtract: product then saturating difference
  logic signed [64:0] diff;
  assign diff = 65'($signed(b_r)) - 65'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      msub_r <= 1'b0;
    end else begin
      fin_r  <= 1'b0;
      msub_r <= (cmd.op == CMD_MSUB);
      if (cmd.op == CMD_DIV) begin
        busy_r <= 1'b1;
        neg_r  <= a_r[31] ^ p_r[31];
        num_r  <= QW'(a_r[31] ? 33'(-$signed({a_r[31], a_r})) : 33'(a_r)) << FRAC_BITS;
        den_r  <= p_r[31] ? 33'(-$signed({p_r[31], p_r})) : {1'b0, p_r};
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= 7'(QW);
      end else if (busy_r) begin
        if (!trial[33]) rem_r <= trial[32:0];
        else            rem_r <= {rem_r[31:0], num_r[QW-1]};
        num_r <= num_r << 1;
        quo_r <= {quo_r[QW-2:0], ~trial[33]};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (cmd.op == CMD_MSUB) prod_r <= $signed(p_r) * $signed(a_r);
      if (msub_r) begin
        if (diff > 65'sd2147483647)       res_r <= 32'h7fffffff;
        else if (diff < -65'sd2147483648) res_r <= 32'h80000000;
        else                              res_r <= diff[31:0];
      end
      if (fin_r) begin
        if (!neg_r) res_r <= (quo_r > QW'(32'h7fffffff)) ? 32'h7fffffff : quo_r[31:0];
        else        res_r <= (quo_r > QW'(33'h80000000)) ? 32'h80000000
                                                        : 32'(-$signed({1'b0, quo_r}));
      end
    end
  end

  assign stat.div_busy = busy_r | fin_r | (cmd.op == CMD_DIV);
  assign stat.rd_zero  = (rd_q_r == '0);
endmodule
`default_nettype wire

FILE: hw/rtl/gjr_ctrl.sv
`default_nettype none
module gjr_ctrl #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  gjr_in_if.sink             in_ch,
  gjr_out_if.source          out_ch,
  gjr_cfg_if.sink            cfg_ch,
  input  gjr_pkg::dp_stat_t  stat,
  input  wire [31:0]         rd_data,
  output gjr_pkg::dp_cmd_t   cmd
);
  import gjr_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_SRCH_RD, S_SRCH_W1, S_SRCH_CHK,
    S_SW_RD1, S_SW_RD2, S_SW_W0, S_SW_W1, S_SW_WR1, S_SW_WR2,
    S_DV_RD, S_DV_W0, S_DV_W1, S_DV_GO, S_DV_WAIT, S_DV_WR,
    S_EL_RDF, S_EL_RDP, S_EL_RDB, S_EL_W0, S_EL_W1, S_EL_MUL, S_EL_SUB, S_EL_WR,
    S_NEXT, S_OUT_RD, S_OUT_W, S_OUT_HOLD
  } state_t;

  state_t     state_r;
  logic [3:0] rows_cfg_r, cols_cfg_r;
  logic [3:0] rows, cols;
  logic [3:0] lr_r, lc_r;          // load position
  logic [3:0] prow_r, lead_r, srow_r, i_r, j_r;
  logic [31:0] val_r;
  logic       ovld_r, olast_r;
  logic [3:0] orow_r, ocol_r;

  // clamp dimensions
  always_comb begin
    rows = (rows_cfg_r == 4'd0) ? 4'd1 :
           (32'(rows_cfg_r) > MAX_ROWS) ? 4'(MAX_ROWS) : rows_cfg_r;
    cols = (cols_cfg_r == 4'd0) ? 4'd1 :
           (32'(cols_cfg_r) > MAX_COLS) ? 4'(MAX_COLS) : cols_cfg_r;
  end

  // register writes only while loading; a write beat holds off the element
  assign in_ch.ready  = (state_r == S_LOAD) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_LOAD);
  assign out_ch.valid = ovld_r;
  assign out_ch.value = val_r;
  assign out_ch.row_index = orow_r[2:0];
  assign out_ch.col_index = ocol_r[2:0];
  assign out_ch.last  = olast_r;

  logic [3:0] i_nxt;
  logic [3:0] ex_nxt;
  always_comb begin
    // next row for elimination, skipping the pivot row
    i_nxt = i_r + 4'd1;
    if (i_nxt == prow_r) i_nxt = i_nxt + 4'd1;
    ex_nxt = srow_r + 4'd1;
  end

  // command decode
  always_comb begin
    cmd = '{op: CMD_NONE, rd_row: 4'd0, rd_col: 4'd0, wr_row: lr_r, wr_col: lc_r,
            sel: SEL_A};
    unique case (state_r)
      S_LOAD:    if (in_ch.valid && in_ch.ready) cmd.op = CMD_LOAD;
      S_SRCH_RD: cmd = '{CMD_READ, srow_r, lead_r, 4'd0, 4'd0, SEL_A};
      S_SW_RD1:  cmd = '{CMD_READ, srow_r, j_r, 4'd0, 4'd0, SEL_A};
      S_SW_RD2:  cmd = '{CMD_READ, prow_r, j_r, 4'd0, 4'd0, SEL_B};
      S_SW_WR1:  cmd = '{CMD_WRITE, 4'd0, 4'd0, prow_r, j_r, SEL_A};
      S_SW_WR2:  cmd = '{CMD_WRITE, 4'd0, 4'd0, srow_r, j_r, SEL_B};
      S_DV_RD:   cmd = '{CMD_READ, prow_r, j_r, 4'd0, 4'd0,
                         (j_r == lead_r) ? SEL_P : SEL_A};
      S_DV_GO:   cmd.op = CMD_DIV;
      S_DV_WR:   cmd = '{CMD_WRITE, 4'd0, 4'd0, prow_r, j_r, SEL_RES};
      S_EL_RDF:  cmd = '{CMD_READ, i_r, lead_r, 4'd0, 4'd0, SEL_P};
      S_EL_RDP:  cmd = '{CMD_READ, prow_r, j_r, 4'd0, 4'd0, SEL_A};
      S_EL_RDB:  cmd = '{CMD_READ, i_r, j_r, 4'd0, 4'd0, SEL_B};
      S_EL_MUL:  cmd.op = CMD_MSUB;
      S_EL_WR:   cmd = '{CMD_WRITE, 4'd0, 4'd0, i_r, j_r, SEL_RES};
      S_OUT_RD:  cmd = '{CMD_READ, i_r, j_r, 4'd0, 4'd0, SEL_A};
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rows_cfg_r <= 4'd8;
      cols_cfg_r <= 4'd8;
      lr_r <= '0; lc_r <= '0;
      prow_r <= '0; lead_r <= '0; srow_r <= '0; i_r <= '0; j_r <= '0;
      ovld_r <= 1'b0; olast_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == 4'(REG_ROWS)) begin
          rows_cfg_r <= cfg_ch.data[3:0]; lr_r <= '0; lc_r <= '0;
        end else if (cfg_ch.index == 4'(REG_COLS)) begin
          cols_cfg_r <= cfg_ch.data[3:0]; lr_r <= '0; lc_r <= '0;
        end
      end
      if (out_ch.ready && ovld_r && state_r != S_OUT_HOLD) ovld_r <= 1'b0;
      unique case (state_r)
        S_LOAD: if (in_ch.valid && in_ch.ready) begin
          // advance load position; last element starts the reduction
          if (lc_r + 4'd1 >= cols) begin
            lc_r <= '0;
            if (lr_r + 4'd1 >= rows) begin
              lr_r <= '0;
              prow_r <= '0; lead_r <= '0; srow_r <= '0;
              state_r <= S_SRCH_RD;
            end else lr_r <= lr_r + 4'd1;
          end else lc_r <= lc_r + 4'd1;
        end
        S_SRCH_RD:  state_r <= S_SRCH_W1;
        S_SRCH_W1:  state_r <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (!stat.rd_zero) begin
            // read pivot first when no swap is needed
            j_r <= (srow_r == prow_r) ? lead_r : 4'd0;
            state_r <= (srow_r != prow_r) ? S_SW_RD1 : S_DV_RD;
          end else if (ex_nxt == rows) begin
            srow_r <= prow_r;
            if (lead_r + 4'd1 == cols) begin
              i_r <= '0; j_r <= '0; state_r <= S_OUT_RD;
            end else begin
              lead_r <= lead_r + 4'd1; state_r <= S_SRCH_RD;
            end
          end else begin
            srow_r <= ex_nxt; state_r <= S_SRCH_RD;
          end
        end
        S_SW_RD1: state_r <= S_SW_RD2;
        S_SW_RD2: state_r <= S_SW_W0;
        S_SW_W0:  state_r <= S_SW_W1;
        S_SW_W1:  state_r <= S_SW_WR1;
        S_SW_WR1: state_r <= S_SW_WR2;
        S_SW_WR2: begin
          if (j_r + 4'd1 == cols) begin
            j_r <= lead_r; state_r <= S_DV_RD;
          end else begin
            j_r <= j_r + 4'd1; state_r <= S_SW_RD1;
          end
        end
        // pivot column first so the pivot is captured before overwrite
        S_DV_RD: state_r <= S_DV_W0;
        S_DV_W0: state_r <= S_DV_W1;
        S_DV_W1: state_r <= S_DV_GO;
        S_DV_GO: state_r <= S_DV_WAIT;
        S_DV_WAIT: if (!stat.div_busy) state_r <= S_DV_WR;
        S_DV_WR: begin
          // wrap around the row starting from the lead column
          if (((j_r + 4'd1 == cols) ? 4'd0 : j_r + 4'd1) == lead_r) begin
            i_r <= (prow_r == 4'd0) ? 4'd1 : 4'd0;
            j_r <= '0;
            state_r <= ((prow_r == 4'd0 ? 4'd1 : 4'd0) >= rows) ? S_NEXT : S_EL_RDF;
          end else begin
            j_r <= (j_r + 4'd1 == cols) ? 4'd0 : j_r + 4'd1;
            state_r <= S_DV_RD;
          end
        end
        S_EL_RDF: state_r <= S_EL_RDP;
        S_EL_RDP: state_r <= S_EL_RDB;
        S_EL_RDB: state_r <= S_EL_W0;
        S_EL_W0:  state_r <= S_EL_W1;
        S_EL_W1:  state_r <= S_EL_MUL;
        S_EL_MUL: state_r <= S_EL_SUB;
        S_EL_SUB: state_r <= S_EL_WR;
        S_EL_WR: begin
          if (j_r + 4'd1 == cols) begin
            j_r <= '0;
            if (i_nxt >= rows) state_r <= S_NEXT;
            else begin i_r <= i_nxt; state_r <= S_EL_RDF; end
          end else begin
            j_r <= j_r + 4'd1;
            state_r <= S_EL_RDP;
          end
        end
        S_NEXT: begin
          if (prow_r + 4'd1 == rows || lead_r + 4'd1 >= cols) begin
            i_r <= '0; j_r <= '0; state_r <= S_OUT_RD;
          end else begin
            prow_r <= prow_r + 4'd1; srow_r <= prow_r + 4'd1;
            lead_r <= lead_r + 4'd1; state_r <= S_SRCH_RD;
          end
        end
        S_OUT_RD: state_r <= S_OUT_W;
        S_OUT_W:  state_r <= S_OUT_HOLD;
        S_OUT_HOLD: if (!ovld_r || out_ch.ready) begin
          // hand one beat to the output register
          ovld_r <= 1'b1;
          val_r  <= rd_data;
          orow_r <= i_r; ocol_r <= j_r;
          olast_r <= (i_r + 4'd1 == rows) && (j_r + 4'd1 == cols);
          if (j_r + 4'd1 == cols) begin
            j_r <= '0;
            if (i_r + 4'd1 == rows) begin
              i_r <= '0; state_r <= S_LOAD;
            end else begin
              i_r <= i_r + 4'd1; state_r <= S_OUT_RD;
            end
          end else begin
            j_r <= j_r + 4'd1; state_r <= S_OUT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gauss_jordan_reduction.sv
`default_nettype none
// Gauss-Jordan reduction to reduced row echelon form on signed Q16.16 words.
// Load rows_in_use x cols_in_use elements row-major, one per beat; the block
// then reduces the matrix in its single-port store and emits every element
// row-major with last on the final beat. Loading accepts one element per cycle
// unless a configuration write holds it off. Reduction is set by the serial
// divider for each element of the pivot row and by the store port for each
// multiply-subtract; output reads each element back from the store in turn.
// Configuration writes are accepted only while the block is loading and hold off
// an element offered in the same cycle; a row or column write restarts loading.
module gauss_jordan_reduction #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_COLS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire       clk,
  input  wire       rst_n,
  gjr_in_if.sink    in_ch,
  gjr_out_if.source out_ch,
  gjr_cfg_if.sink   cfg_ch
);
  import gjr_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] rd_data;

  gjr_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_ch, .stat, .rd_data, .cmd
  );

  gjr_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .load_data(in_ch.element), .stat, .rd_data
  );
endmodule
`default_nettype wire

FILE: verif/gjr_checker.sv
`timescale 1ns / 100ps
// Watch all three channels, predict the reduced matrix and compare results.
module gjr_checker
  import gjr_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  gjr_in_if    in_ch,
  gjr_out_if   out_ch,
  gjr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   results_due
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic               last;
  } rref_elem_t;

  logic [3:0]         rows_reg, cols_reg;
  logic signed [31:0] mat [8][8];
  int                 loaded;
  rref_elem_t         rref_q[$];

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int dim_used(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  // Gauss-Jordan on the shadow matrix
  function automatic void rref_reduce(int nr, int nc);
    int lead, srow, f;
    logic signed [31:0] piv, fac, t;
    longint prod;
    lead = 0;
    for (int p = 0; p < nr; p++) begin
      if (lead >= nc) return;
      srow = p;
      while (mat[srow][lead] == 0) begin
        srow++;
        if (srow == nr) begin
          srow = p;
          lead++;
          if (lead == nc) return;
        end
      end
      // swap rows into place
      for (int j = 0; j < nc; j++) begin
        t = mat[srow][j];
        mat[srow][j] = mat[p][j];
        mat[p][j] = t;
      end
      piv = mat[p][lead];
      for (int j = 0; j < nc; j++)
        mat[p][j] = clip32((longint'(mat[p][j]) * 65536) / longint'(piv));
      for (int i = 0; i < nr; i++) begin
        if (i == p) continue;
        fac = mat[i][lead];
        for (int j = 0; j < nc; j++) begin
          prod = (longint'(fac) * longint'(mat[p][j])) >>> 16;
          mat[i][j] = clip32(longint'(mat[i][j]) - prod);
        end
      end
      lead++;
    end
  endfunction

  assign results_due = rref_q.size();

  always @(posedge clk) begin
    int nr, nc;
    int errs;
    rref_elem_t exp_e;
    errs = 0;
    if (!rst_n) begin
      rows_reg <= 4'd8;
      cols_reg <= 4'd8;
      loaded = 0;
      fail_count <= 0;
      rref_q.delete();
    end else begin
      // register writes restart loading
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ROWS) begin
          rows_reg <= cfg_ch.data[3:0];
          loaded = 0;
        end else if (cfg_ch.index == REG_COLS) begin
          cols_reg <= cfg_ch.data[3:0];
          loaded = 0;
        end
      end
      // load one element; predict on the closing beat
      if (in_ch.valid && in_ch.ready) begin
        nr = dim_used(rows_reg);
        nc = dim_used(cols_reg);
        if (loaded >= nr * nc) loaded = 0;
        mat[loaded / nc][loaded % nc] = in_ch.element;
        loaded++;
        if (loaded == nr * nc) begin
          rref_reduce(nr, nc);
          loaded = 0;
          for (int k = 0; k < nr * nc; k++) begin
            exp_e.value     = mat[k / nc][k % nc];
            exp_e.row_index = 3'(k / nc);
            exp_e.col_index = 3'(k % nc);
            exp_e.last      = (k + 1 == nr * nc);
            rref_q.push_back(exp_e);
          end
        end
      end
      // compare each result beat with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (rref_q.size() == 0) begin
          $error("unexpected result beat value=%h", out_ch.value);
          errs++;
        end else begin
          exp_e = rref_q.pop_front();
          if (out_ch.value !== exp_e.value) begin
            $error("value: expected %h, got %h", exp_e.value, out_ch.value);
            errs++;
          end
          if (out_ch.row_index !== exp_e.row_index) begin
            $error("row_index: expected %0d, got %0d", exp_e.row_index, out_ch.row_index);
            errs++;
          end
          if (out_ch.col_index !== exp_e.col_index) begin
            $error("col_index: expected %0d, got %0d", exp_e.col_index, out_ch.col_index);
            errs++;
          end
          if (out_ch.last !== exp_e.last) begin
            $error("last: expected %0d, got %0d", exp_e.last, out_ch.last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import gjr_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, results_due;
  int   send_idle, recv_idle;
  logic hold_req;
  int   hold_left;

  gjr_in_if  in_ch ();
  gjr_out_if out_ch ();
  gjr_cfg_if cfg_ch ();

  gauss_jordan_reduction dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  gjr_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= 15000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_elem(input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results, then let the block settle before a register write
  task automatic drain();
    while (results_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0, 1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom();
      default: return (32'($urandom_range(0, 16)) - 32'd8) << 16 | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_matrix(input int nr, input int nc);
    for (int k = 0; k < nr * nc; k++) send_elem(pick_elem());
    end_burst();
  endtask

  task automatic set_dims(input logic [3:0] r, input logic [3:0] c);
    drain();
    write_reg(REG_ROWS, {28'($urandom()), r});
    write_reg(REG_COLS, {28'($urandom()), c});
  endtask

  initial begin
    int nr, nc, sent;
    rst_n = 1'b0;
    hold_req = 1'b0;
    send_idle = 35;
    recv_idle = 61;
    in_ch.valid = 1'b0;
    in_ch.element = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 1x1 extremes, zero pivot, saturation
    set_dims(4'd1, 4'd1);
    send_elem(32'h0); send_elem(32'h7fffffff); send_elem(32'h80000000);
    send_elem(32'h00000001); send_elem(32'hffffffff); send_elem(32'h00010000);
    end_burst();
    // zero register reads as one
    set_dims(4'd0, 4'd0);
    send_elem(32'h00030000);
    end_burst();
    // a dead lead column
    set_dims(4'd2, 4'd3);
    send_elem(32'h0); send_elem(32'h00010000); send_elem(32'h00020000);
    send_elem(32'h0); send_elem(32'h00030000); send_elem(32'hfffe0000);
    end_burst();
    // all-zero matrix exhausts the pivot search
    set_dims(4'd2, 4'd2);
    repeat (4) send_elem(32'h0);
    end_burst();
    // tiny pivot drives quotients to saturation
    send_elem(32'h00000001); send_elem(32'h7fffffff);
    send_elem(32'h80000000); send_elem(32'h7fffffff);
    end_burst();

    // full size with oversize registers, receiver held off meanwhile
    set_dims(4'd15, 4'd9);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_matrix(8, 8);
    send_matrix(8, 8);

    // random phases: swap idling, then none
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 61; recv_idle = 35; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      while (sent < 24 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) begin nr = 2; nc = 8; end
        else begin nr = $urandom_range(1, 4); nc = $urandom_range(1, 5); end
        set_dims(4'(nr), 4'(nc));
        // occasionally restart loading partway
        if ($urandom_range(0, 7) == 0 && nr * nc > 1) begin
          for (int k = 0; k < $urandom_range(1, nr * nc - 1); k++) send_elem(pick_elem());
          end_burst();
          repeat (5) @(posedge clk);
          write_reg(REG_COLS, 32'(nc));
        end
        send_matrix(nr, nc);
        sent += nr * nc;
      end
    end

    while (results_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
